// ===== rtl/core/spd_pkg.sv =====
`timescale 1ns / 1ps
package spd_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int VERT_W       = 5;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int ADDR_W       = 2 * VIDX_W;
  localparam int WEIGHT_W     = 10;
  localparam int DEPTH        = MAX_VERTICES * MAX_VERTICES;

  localparam logic [WEIGHT_W-1:0] NO_EDGE      = WEIGHT_W'(999);
  localparam logic [VERT_W-1:0]   SRC_VERTEX   = VERT_W'(1);
  localparam logic [VERT_W-1:0]   VCOUNT_RESET = VERT_W'(16);
  localparam logic [VERT_W-1:0]   VCOUNT_MAX   = VERT_W'(MAX_VERTICES);
  localparam logic [VERT_W-1:0]   VCOUNT_MIN   = VERT_W'(2);

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_RUN   = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [VERT_W-1:0]   from_vertex;
    logic [VERT_W-1:0]   to_vertex;
    logic [WEIGHT_W-1:0] edge_weight;
  } spd_req_t;

  typedef struct packed {
    logic [VERT_W-1:0]   tree_from;
    logic [VERT_W-1:0]   tree_to;
    logic [WEIGHT_W-1:0] tree_weight;
    logic                last;
  } spd_res_t;

  typedef struct packed {
    logic                en;
    logic [ADDR_W-1:0]   addr;
    logic [WEIGHT_W-1:0] data;
  } spd_wr_t;

  // vertices are numbered from 1; the matrix row is the tail vertex
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [VERT_W-1:0] from_v,
                                                  input logic [VERT_W-1:0] to_v);
    logic [VERT_W-1:0] fm1;
    logic [VERT_W-1:0] tm1;
    fm1 = from_v - VERT_W'(1);
    tm1 = to_v - VERT_W'(1);
    return {fm1[VIDX_W-1:0], tm1[VIDX_W-1:0]};
  endfunction

endpackage

// ===== rtl/core/spd_matrix.sv =====
`timescale 1ns / 1ps
module spd_matrix (
  input  logic                          clk,
  input  logic                          rst,
  input  spd_pkg::spd_wr_t              wr,
  input  logic [spd_pkg::ADDR_W-1:0]    rd_addr,
  output logic [spd_pkg::WEIGHT_W-1:0]  rd_data
);
  import spd_pkg::*;

  logic [WEIGHT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]    written;
  logic [WEIGHT_W-1:0] mem_q;
  logic                written_q;
  logic                diag_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    mem_q  <= mem[rd_addr];
    diag_q <= (rd_addr[ADDR_W-1:VIDX_W] == rd_addr[VIDX_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      written_q <= written[rd_addr];
    end
  end

  // untouched entries read as the power-up matrix
  assign rd_data = written_q ? mem_q : (diag_q ? '0 : NO_EDGE);

endmodule

// ===== rtl/core/spd_ctrl.sv =====
`timescale 1ns / 1ps
module spd_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          run,
  input  logic [spd_pkg::VERT_W-1:0]    vertex_count,
  input  logic [spd_pkg::WEIGHT_W-1:0]  rd_data,
  output logic [spd_pkg::ADDR_W-1:0]    rd_addr,
  output logic                          busy,
  output logic                          result_valid,
  output spd_pkg::spd_res_t             result
);
  import spd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_EMIT_RD,
    S_EMIT,
    S_RELAX
  } state_t;

  state_t               state;
  logic [VERT_W-1:0]    n;
  logic [VERT_W-1:0]    v;
  logic [VERT_W-1:0]    v_d;
  logic                 vld_d;
  logic [VERT_W-1:0]    pass;
  logic [VERT_W-1:0]    best;
  logic [VERT_W-1:0]    best_pred;
  logic [WEIGHT_W-1:0]  bestd;
  logic [WEIGHT_W-1:0]  distance [MAX_VERTICES];
  logic [VERT_W-1:0]    pred [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] fin;

  logic [VERT_W-1:0]    v_m1;
  logic [VERT_W-1:0]    vd_m1;
  logic [VERT_W-1:0]    best_m1;
  logic [VIDX_W-1:0]    vd_idx;
  logic [VIDX_W-1:0]    best_idx;
  logic [VIDX_W-1:0]    dr_idx;
  logic [WEIGHT_W-1:0]  dist_rd;
  logic [VERT_W-1:0]    pred_rd;
  logic                 fin_rd;
  logic [WEIGHT_W:0]    sum;
  logic                 scan_pick;
  logic                 relax_upd;

  always_comb begin
    v_m1     = v - VERT_W'(1);
    vd_m1    = v_d - VERT_W'(1);
    best_m1  = best - VERT_W'(1);
    vd_idx   = vd_m1[VIDX_W-1:0];
    best_idx = best_m1[VIDX_W-1:0];
    // scan walks v, the relax write-back walks the delayed index
    dr_idx   = (state == S_SCAN) ? v_m1[VIDX_W-1:0] : vd_idx;
    dist_rd  = distance[dr_idx];
    pred_rd  = pred[dr_idx];
    fin_rd   = fin[dr_idx];
    sum      = {1'b0, bestd} + {1'b0, rd_data};
    scan_pick = !fin_rd && (dist_rd <= bestd);
    relax_upd = vld_d && !fin_rd && (v_d != best) && (sum < {1'b0, dist_rd});
    case (state)
      S_INIT:    rd_addr = cell_addr(SRC_VERTEX, v);
      S_EMIT_RD: rd_addr = cell_addr(best_pred, best);
      default:   rd_addr = cell_addr(best, v);
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      vld_d        <= 1'b0;
      fin          <= '0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (run) begin
            n     <= vertex_count;
            v     <= VCOUNT_MIN;
            vld_d <= 1'b0;
            pass  <= VERT_W'(1);
            state <= S_INIT;
          end
        end
        S_INIT: begin
          v_d   <= v;
          vld_d <= (v <= n);
          if (vld_d) begin
            distance[vd_idx] <= rd_data;
            pred[vd_idx]     <= SRC_VERTEX;
            fin[vd_idx]      <= 1'b0;
          end
          if (v <= n) begin
            v <= v + VERT_W'(1);
          end else begin
            state     <= S_SCAN;
            v         <= VCOUNT_MIN;
            bestd     <= NO_EDGE;
            best      <= '0;
            best_pred <= SRC_VERTEX;
          end
        end
        S_SCAN: begin
          // <= lets the highest index win a tie
          if (scan_pick) begin
            bestd     <= dist_rd;
            best      <= v;
            best_pred <= pred_rd;
          end
          if (v == n) begin
            state <= S_EMIT_RD;
          end else begin
            v <= v + VERT_W'(1);
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          result_valid       <= 1'b1;
          result.tree_from   <= best_pred;
          result.tree_to     <= best;
          result.tree_weight <= rd_data;
          result.last        <= (pass == n - VERT_W'(1));
          if (pass == n - VERT_W'(1)) begin
            state <= S_IDLE;
          end else begin
            state <= S_RELAX;
            v     <= VCOUNT_MIN;
            vld_d <= 1'b0;
          end
        end
        S_RELAX: begin
          v_d   <= v;
          vld_d <= (v <= n);
          if (relax_upd) begin
            distance[vd_idx] <= sum[WEIGHT_W-1:0];
            pred[vd_idx]     <= best;
          end
          if (v <= n) begin
            v <= v + VERT_W'(1);
          end else begin
            fin[best_idx] <= 1'b1;
            pass      <= pass + VERT_W'(1);
            state     <= S_SCAN;
            v         <= VCOUNT_MIN;
            bestd     <= NO_EDGE;
            best      <= '0;
            best_pred <= SRC_VERTEX;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/shortest_path_tree_dijkstra_unit.sv =====
`timescale 1ns / 1ps
// write request: taken while idle and busy stays low, so writes may follow back to back
// run request over n vertices: load row 1, then n-1 passes of a one-vertex-per-cycle minimum
// scan, a matrix read and a relax sweep (none on the last pass)
// edges come one per pass on result_valid for one cycle each; the receiver cannot stall
// synchronous rst: matrix back to its power-up contents, vertex_count 16, block idle
module shortest_path_tree_dijkstra_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  spd_pkg::spd_req_t            req,
  input  logic                         cfg_we,
  input  logic [spd_pkg::VERT_W-1:0]   cfg_data,
  output logic                         result_valid,
  output spd_pkg::spd_res_t            result
);
  import spd_pkg::*;

  logic [VERT_W-1:0]   vertex_count;
  logic [VERT_W-1:0]   n_clamped;
  logic                accept;
  logic                run;
  logic                from_ok;
  logic                to_ok;
  spd_wr_t             wr;
  logic [ADDR_W-1:0]   rd_addr;
  logic [WEIGHT_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
    end else if (cfg_we) begin
      vertex_count <= cfg_data;
    end
  end

  always_comb begin
    accept    = start && !busy;
    n_clamped = (vertex_count > VCOUNT_MAX) ? VCOUNT_MAX : vertex_count;
    // fewer than two vertices gives an empty tree
    run       = accept && (req.mode == MODE_RUN) && (n_clamped >= VCOUNT_MIN);
    from_ok   = (req.from_vertex != '0) && (req.from_vertex <= VCOUNT_MAX);
    to_ok     = (req.to_vertex != '0) && (req.to_vertex <= VCOUNT_MAX);
    wr.en     = accept && (req.mode == MODE_WRITE) && from_ok && to_ok;
    wr.addr   = cell_addr(req.from_vertex, req.to_vertex);
    wr.data   = (req.edge_weight > NO_EDGE) ? NO_EDGE : req.edge_weight;
  end

  spd_matrix u_matrix (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  spd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .run          (run),
    .vertex_count (n_clamped),
    .rd_data      (rd_data),
    .rd_addr      (rd_addr),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ===== rtl/core/spd_chk.sv =====
`timescale 1ns / 1ps
module spd_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        result_valid,
  input spd_pkg::spd_res_t           result
);
  import spd_pkg::*;

  // every edge but the final one comes while the run still holds busy
  a_mid_edge_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy)
    else $error("non-final edge shown while idle");

  // a freshly taken request never produces an edge in the next cycle
  a_no_edge_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !result_valid)
    else $error("edge right after a request was taken");

  // a new request may be taken alongside the final edge, so only the strobe is checked
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |=> !result_valid)
    else $error("activity after the final edge");

  // tree edges never loop, never end at vertex 0 and never carry a weight above the no-edge mark
  a_edge_sane: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.tree_from != result.tree_to) &&
                     (result.tree_weight <= NO_EDGE) && (result.tree_to != '0))
    else $error("malformed tree edge");

endmodule

bind shortest_path_tree_dijkstra_unit spd_chk u_spd_chk (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import spd_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 2 * MAX_VERTICES * MAX_VERTICES + 64;
  localparam int MAX_REPORTS    = 10;
  localparam int IDLE_PERCENT   = 15;
  localparam int CALM_START     = 3000;
  localparam int CALM_END       = 12000;
  localparam int NUM_PHASES     = 10;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  spd_req_t            req = '0;
  logic                cfg_we = 1'b0;
  logic [VERT_W-1:0]   cfg_data = '0;
  logic                result_valid;
  spd_res_t            result;

  shortest_path_tree_dijkstra_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  spd_req_t            pending_reqs[$];
  spd_res_t            expected_edges[$];
  logic [WEIGHT_W-1:0] weight_model [1:MAX_VERTICES][1:MAX_VERTICES];
  logic [VERT_W-1:0]   vcount_model;
  logic                req_taken = 1'b0;

  int queued_count     = 0;
  int accepted_count   = 0;
  int writes_accepted  = 0;
  int runs_accepted    = 0;
  int edges_checked    = 0;
  int mismatch_count   = 0;
  int settings_applied = 0;
  int idle_watch       = 0;
  int cycle_count      = 0;

  // expected tree edges of one run, built from the model matrix
  function automatic void predict_tree();
    int               n;
    int               best;
    int               bestd;
    int               sum;
    int               distance [1:MAX_VERTICES];
    logic [VERT_W-1:0] pred [1:MAX_VERTICES];
    bit               done [1:MAX_VERTICES];
    spd_res_t         edge_exp;
    n = (vcount_model > VCOUNT_MAX) ? MAX_VERTICES : int'(vcount_model);
    if (n < 2) return;
    for (int v = 2; v <= n; v++) begin
      pred[v]     = SRC_VERTEX;
      distance[v] = int'(weight_model[1][v]);
      done[v]     = 1'b0;
    end
    for (int pass = 1; pass < n; pass++) begin
      best  = 0;
      bestd = int'(NO_EDGE);
      // highest index wins a tie, unreachable ones included
      for (int v = 2; v <= n; v++) begin
        if (!done[v] && distance[v] <= bestd) begin
          bestd = distance[v];
          best  = v;
        end
      end
      if (best == 0) break;
      edge_exp.tree_from   = pred[best];
      edge_exp.tree_to     = VERT_W'(best);
      edge_exp.tree_weight = weight_model[pred[best]][best];
      edge_exp.last        = (pass == n - 1);
      expected_edges.push_back(edge_exp);
      for (int v = 2; v <= n; v++) begin
        if (!done[v] && v != best) begin
          sum = distance[best] + int'(weight_model[best][v]);
          if (sum < distance[v]) begin
            distance[v] = sum;
            pred[v]     = VERT_W'(best);
          end
        end
      end
      done[best] = 1'b1;
    end
  endfunction

  function automatic void apply_write(spd_req_t r);
    int f;
    int t;
    f = int'(r.from_vertex);
    t = int'(r.to_vertex);
    if (f < 1 || f > MAX_VERTICES || t < 1 || t > MAX_VERTICES) return;
    weight_model[f][t] = (r.edge_weight > NO_EDGE) ? NO_EDGE : r.edge_weight;
  endfunction

  // monitor: result check first, then the request taken at the same edge
  always @(posedge clk) begin
    spd_res_t exp_edge;
    bit       accepted;
    if (rst) begin
      for (int r = 1; r <= MAX_VERTICES; r++) begin
        for (int c = 1; c <= MAX_VERTICES; c++) begin
          weight_model[r][c] = (r == c) ? '0 : NO_EDGE;
        end
      end
      vcount_model = VCOUNT_RESET;
      req_taken <= 1'b0;
    end else begin
      cycle_count++;
      if (result_valid) begin
        if (expected_edges.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: unexpected tree edge", $realtime,
                     " from=%0d to=%0d weight=%0d last=%0b",
                     result.tree_from, result.tree_to, result.tree_weight, result.last);
        end else begin
          exp_edge = expected_edges.pop_front();
          edges_checked++;
          if (result.tree_from !== exp_edge.tree_from || result.tree_to !== exp_edge.tree_to ||
              result.tree_weight !== exp_edge.tree_weight || result.last !== exp_edge.last) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("%0t: edge mismatch exp from=%0d to=%0d weight=%0d last=%0b,",
                       $realtime, exp_edge.tree_from, exp_edge.tree_to,
                       exp_edge.tree_weight, exp_edge.last,
                       " got from=%0d to=%0d weight=%0d last=%0b",
                       result.tree_from, result.tree_to, result.tree_weight,
                       result.last);
          end
        end
      end
      accepted = start && !busy;
      if (accepted) begin
        accepted_count++;
        if (req.mode == MODE_RUN) begin
          runs_accepted++;
          predict_tree();
        end else begin
          writes_accepted++;
          apply_write(req);
        end
      end
      // the register takes the new count at this edge, after any run request
      if (cfg_we) vcount_model = cfg_data;
      req_taken <= accepted;
      if (accepted || result_valid) begin
        idle_watch = 0;
      end else begin
        idle_watch++;
        if (idle_watch >= WATCHDOG_LIMIT) begin
          $display("%0t: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  // driver: a request stays up until taken, gaps only between requests
  always @(negedge clk) begin
    bit calm;
    calm = (cycle_count >= CALM_START && cycle_count < CALM_END);
    if (rst) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
        req   <= pending_reqs.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic push_write(input int f, input int t, input int w);
    spd_req_t r;
    r.mode        = MODE_WRITE;
    r.from_vertex = VERT_W'(f);
    r.to_vertex   = VERT_W'(t);
    r.edge_weight = WEIGHT_W'(w);
    pending_reqs.push_back(r);
    queued_count++;
  endtask

  task automatic push_run();
    spd_req_t r;
    r             = spd_req_t'($urandom);
    r.mode        = MODE_RUN;
    pending_reqs.push_back(r);
    queued_count++;
  endtask

  function automatic int rand_vertex(input int nv);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return $urandom_range(1, nv);
    if (roll < 90) return 0;
    if (roll < 95) return $urandom_range(MAX_VERTICES + 1, 31);
    return $urandom_range(1, MAX_VERTICES);
  endfunction

  function automatic int rand_weight();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return $urandom_range(0, 15);
    if (roll < 75) return int'(NO_EDGE);
    if (roll < 85) return $urandom_range(int'(NO_EDGE) + 1, 1023);
    return $urandom_range(0, 1023);
  endfunction

  // mostly a few edge writes followed by a run, with bare runs and stray writes mixed in
  task automatic fill_random(input int nv, input int count);
    int made;
    int nw;
    int roll;
    made = 0;
    while (made < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        nw = $urandom_range(1, 8);
        repeat (nw) push_write(rand_vertex(nv), rand_vertex(nv), rand_weight());
        push_run();
        made += nw + 1;
      end else if (roll < 93) begin
        push_run();
        made++;
      end else begin
        push_write($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1023));
        made++;
      end
    end
  endtask

  task automatic wait_drain();
    while (accepted_count != queued_count || expected_edges.size() != 0 || busy)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_vcount(input int value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= VERT_W'(value);
    @(negedge clk);
    cfg_we   <= 1'b0;
    settings_applied++;
  endtask

  initial begin
    int cfg_plan [NUM_PHASES];
    int nv;
    cfg_plan = '{2, 0, 1, 31, 16, 17, 9, 3, 0, 0};
    cfg_plan[NUM_PHASES-2] = $urandom_range(2, MAX_VERTICES);
    cfg_plan[NUM_PHASES-1] = $urandom_range(2, MAX_VERTICES);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // power-up matrix: every vertex unreachable, highest index first
    push_run();
    push_write(1, 2, 0);
    push_write(1, 3, 1023);      // saturates to no edge
    push_write(0, 2, 5);         // ignored
    push_write(2, 17, 5);        // ignored
    push_write(31, 31, 1);       // ignored
    push_write(2, 3, 4);
    push_write(3, 3, 7);         // diagonal
    push_write(1, 16, 998);
    push_write(2, 16, 0);
    push_write(3, 4, 1);
    push_write(1, 4, 5);         // equal path length, no update
    push_write(1, 5, 3);
    push_write(1, 6, 3);         // tie at the minimum
    push_write(6, 7, 999);
    push_write(5, 8, 1000);
    push_write(8, 9, 0);
    push_run();
    push_write(1, 2, 999);
    push_write(16, 1, 0);
    push_run();
    wait_drain();

    foreach (cfg_plan[i]) begin
      write_vcount(cfg_plan[i]);
      nv = (cfg_plan[i] > MAX_VERTICES) ? MAX_VERTICES : cfg_plan[i];
      if (nv < 2) begin
        // runs give nothing here, only the writes land
        push_write(MAX_VERTICES, MAX_VERTICES - 1, 3);
        push_run();
        fill_random(MAX_VERTICES, 12);
      end else begin
        push_run();
        fill_random(nv, 58);
      end
      wait_drain();
    end

    $display("covered %0d edge writes and %0d runs over %0d vertex_count settings",
             writes_accepted, runs_accepted, settings_applied + 1);
    $display("checked %0d tree edges, %0d mismatches", edges_checked, mismatch_count);
    if (mismatch_count == 0 && expected_edges.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
